// ===== hw/rtl/orbm_pkg.sv =====
`timescale 1ns / 1ps
package orbm_pkg;

  localparam int FIELD_W = 32;
  localparam int DW      = 34;
  localparam int PW      = 2 * DW;
  localparam int PC_W    = 5;
  localparam int CFG_IDX_W = 4;
  localparam int TRIG_FRAC = 30;
  localparam int ATAN_ENTRIES = 24;

  localparam logic signed [DW-1:0] CORDIC_GAIN = DW'(652032874);

  localparam logic [PC_W-1:0] PC_MATRIX_END = PC_W'(22);
  localparam logic [PC_W-1:0] PC_ORBIT_BEGIN = PC_W'(23);
  localparam logic [PC_W-1:0] PC_ORBIT_END = PC_W'(24);

  typedef logic signed [DW-1:0] sval_t;

  typedef enum logic [1:0] {
    MODE_SPIN    = 2'd0,
    MODE_ADVANCE = 2'd1,
    MODE_ORBIT   = 2'd2,
    MODE_EMIT    = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORBIT_RADIUS = 4'd0,
    REG_ORBIT_SPEED  = 4'd1,
    REG_SCALE_X      = 4'd2,
    REG_SCALE_Y      = 4'd3,
    REG_SCALE_Z      = 4'd4,
    REG_TILT_X       = 4'd5,
    REG_TILT_Y       = 4'd6,
    REG_HEIGHT_Z     = 4'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    TRIG_TILT_X = 2'd0,
    TRIG_TILT_Y = 2'd1,
    TRIG_SPIN   = 2'd2,
    TRIG_ORBIT  = 2'd3
  } trig_sel_t;

  typedef enum logic [4:0] {
    S_CX, S_SX, S_CY, S_SY, S_CZ, S_SZ, S_P1, S_P2,
    S_R00, S_R01, S_R02, S_R10, S_R11, S_R12, S_R20, S_R21, S_R22,
    S_SCX, S_SCY, S_SCZ, S_RAD, S_LOCX, S_LOCY
  } src_t;

  typedef enum logic [2:0] {
    OP_SET, OP_NEG, OP_ADD, OP_SUB, OP_SAT, OP_LOC
  } op_t;

  typedef struct packed {
    src_t a;
    src_t b;
    op_t  op;
    src_t dst;
  } step_t;

  function automatic step_t mk(src_t a, src_t b, op_t op, src_t dst);
    step_t s;
    s.a = a;
    s.b = b;
    s.op = op;
    s.dst = dst;
    return s;
  endfunction

  // Product program: rotation entries, then column scaling, then the orbit step.
  function automatic step_t prog_step(logic [PC_W-1:0] pc);
    step_t s;
    case (pc)
      5'd0:  s = mk(S_SY, S_CZ, OP_SET, S_P1);
      5'd1:  s = mk(S_SY, S_SZ, OP_SET, S_P2);
      5'd2:  s = mk(S_CY, S_CZ, OP_SET, S_R00);
      5'd3:  s = mk(S_CY, S_SZ, OP_NEG, S_R01);
      5'd4:  s = mk(S_CX, S_SZ, OP_SET, S_R10);
      5'd5:  s = mk(S_SX, S_P1, OP_ADD, S_R10);
      5'd6:  s = mk(S_CX, S_CZ, OP_SET, S_R11);
      5'd7:  s = mk(S_SX, S_P2, OP_SUB, S_R11);
      5'd8:  s = mk(S_SX, S_CY, OP_NEG, S_R12);
      5'd9:  s = mk(S_SX, S_SZ, OP_SET, S_R20);
      5'd10: s = mk(S_CX, S_P1, OP_SUB, S_R20);
      5'd11: s = mk(S_SX, S_CZ, OP_SET, S_R21);
      5'd12: s = mk(S_CX, S_P2, OP_ADD, S_R21);
      5'd13: s = mk(S_CX, S_CY, OP_SET, S_R22);
      5'd14: s = mk(S_R00, S_SCX, OP_SAT, S_R00);
      5'd15: s = mk(S_R10, S_SCX, OP_SAT, S_R10);
      5'd16: s = mk(S_R20, S_SCX, OP_SAT, S_R20);
      5'd17: s = mk(S_R01, S_SCY, OP_SAT, S_R01);
      5'd18: s = mk(S_R11, S_SCY, OP_SAT, S_R11);
      5'd19: s = mk(S_R21, S_SCY, OP_SAT, S_R21);
      5'd20: s = mk(S_SY, S_SCZ, OP_SAT, S_R02);
      5'd21: s = mk(S_R12, S_SCZ, OP_SAT, S_R12);
      5'd22: s = mk(S_R22, S_SCZ, OP_SAT, S_R22);
      5'd23: s = mk(S_RAD, S_CZ, OP_LOC, S_LOCX);
      5'd24: s = mk(S_RAD, S_SZ, OP_LOC, S_LOCY);
      default: s = mk(S_CX, S_CX, OP_SET, S_P1);
    endcase
    return s;
  endfunction

  function automatic sval_t atan_unit(logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return sval_t'({2'b00, v});
  endfunction

  function automatic logic [FIELD_W-1:0] sat32(logic signed [39:0] v);
    logic [FIELD_W-1:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'h7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/orbm_if.sv =====
`timescale 1ns / 1ps
interface orbm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] spin_step;
  modport source(output valid, mode, center_x, center_y, spin_step, input ready);
  modport sink(input valid, mode, center_x, center_y, spin_step, output ready);
endinterface

interface orbm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         column;
  logic signed [31:0] elem_row0;
  logic signed [31:0] elem_row1;
  logic signed [31:0] elem_row2;
  logic signed [31:0] elem_row3;
  logic               last;
  modport source(output valid, column, elem_row0, elem_row1, elem_row2, elem_row3, last,
                 input ready);
  modport sink(input valid, column, elem_row0, elem_row1, elem_row2, elem_row3, last,
               output ready);
endinterface

interface orbm_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/orbit_and_model_matrix_core.sv =====
`timescale 1ns / 1ps
// Orbit and model matrix core. Modes 0 and 1 update the spin or orbit angle in the cycle the
// transaction is accepted. Mode 2 runs one CORDIC pass and two products. Mode 3 runs three
// CORDIC passes and a program of 23 products through one shared multiplier, then delivers
// four column transactions. The input is not ready while an item is in progress or its
// columns are still waiting.
module orbit_and_model_matrix_core #(
  parameter int FRAC_BITS       = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input logic clk,
  input logic rst_n,
  orbm_in_if.sink    in_ch,
  orbm_out_if.source out_ch,
  orbm_cfg_if.sink   cfg_ch
);
  import orbm_pkg::*;

  localparam int ITW = $clog2(TRIG_ITERATIONS);
  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

  typedef enum logic [2:0] {ST_IDLE, ST_TLOAD, ST_TRIG, ST_MUL, ST_DRAIN, ST_OUT} state_t;

  state_t state_r;
  logic [30:0] radius_r;
  logic [31:0] speed_r, scx_r, scy_r, scz_r, tiltx_r, tilty_r, height_r;
  logic [31:0] locx_r, locy_r, spin_r, orbit_r;
  logic [31:0] cenx_r, ceny_r;
  logic        emit_r;
  trig_sel_t   tsel_r;
  logic [ITW-1:0] it_r;
  sval_t x_r, y_r, z_r;
  logic  flip_r;
  sval_t cx_r, sx_r, cy_r, sy_r, cz_r, sz_r, p1_r, p2_r;
  sval_t r00_r, r01_r, r02_r, r10_r, r11_r, r12_r, r20_r, r21_r, r22_r;
  logic [PC_W-1:0] pc_r;
  logic signed [PW-1:0] prod_r;
  logic  wb_vld_r;
  step_t wb_step_r;
  logic [1:0] col_r;

  step_t cur_step;
  sval_t op_a, op_b, dst_cur, wb_val;
  logic [31:0] tangle, tfold;
  logic  tflip;
  sval_t nx, ny, nz, xs, ys;
  logic signed [PW-1:0] rs_full;
  logic signed [37:0] rs;
  logic [31:0] loc_val;

  function automatic sval_t pick(src_t s, sval_t cx, sval_t sx, sval_t cy, sval_t sy,
                                 sval_t cz, sval_t sz, sval_t p1, sval_t p2,
                                 sval_t r00, sval_t r01, sval_t r10, sval_t r11,
                                 sval_t r12, sval_t r20, sval_t r21, sval_t r22,
                                 logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                 logic [30:0] rad);
    sval_t v;
    case (s)
      S_CX:  v = cx;
      S_SX:  v = sx;
      S_CY:  v = cy;
      S_SY:  v = sy;
      S_CZ:  v = cz;
      S_SZ:  v = sz;
      S_P1:  v = p1;
      S_P2:  v = p2;
      S_R00: v = r00;
      S_R01: v = r01;
      S_R10: v = r10;
      S_R11: v = r11;
      S_R12: v = r12;
      S_R20: v = r20;
      S_R21: v = r21;
      S_R22: v = r22;
      S_SCX: v = sval_t'($signed(a));
      S_SCY: v = sval_t'($signed(b));
      S_SCZ: v = sval_t'($signed(c));
      S_RAD: v = sval_t'({3'b000, rad});
      default: v = '0;
    endcase
    return v;
  endfunction

  assign cur_step = prog_step(pc_r);
  assign op_a = pick(cur_step.a, cx_r, sx_r, cy_r, sy_r, cz_r, sz_r, p1_r, p2_r, r00_r, r01_r,
                     r10_r, r11_r, r12_r, r20_r, r21_r, r22_r, scx_r, scy_r, scz_r, radius_r);
  assign op_b = pick(cur_step.b, cx_r, sx_r, cy_r, sy_r, cz_r, sz_r, p1_r, p2_r, r00_r, r01_r,
                     r10_r, r11_r, r12_r, r20_r, r21_r, r22_r, scx_r, scy_r, scz_r, radius_r);

  // Round to nearest with halves upward, then drop the trig fraction bits.
  assign rs_full = (prod_r + (PW'(1) <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
  assign rs = rs_full[37:0];

  always_comb begin
    case (wb_step_r.dst)
      S_P1:  dst_cur = p1_r;
      S_P2:  dst_cur = p2_r;
      S_R00: dst_cur = r00_r;
      S_R01: dst_cur = r01_r;
      S_R02: dst_cur = r02_r;
      S_R10: dst_cur = r10_r;
      S_R11: dst_cur = r11_r;
      S_R12: dst_cur = r12_r;
      S_R20: dst_cur = r20_r;
      S_R21: dst_cur = r21_r;
      S_R22: dst_cur = r22_r;
      default: dst_cur = '0;
    endcase
    case (wb_step_r.op)
      OP_SET:  wb_val = rs[DW-1:0];
      OP_NEG:  wb_val = -rs[DW-1:0];
      OP_ADD:  wb_val = dst_cur + rs[DW-1:0];
      OP_SUB:  wb_val = dst_cur - rs[DW-1:0];
      OP_SAT:  wb_val = sval_t'($signed(sat32(40'(rs))));
      default: wb_val = rs[DW-1:0];
    endcase
    if (wb_step_r.dst == S_LOCX) begin
      loc_val = sat32(40'($signed(cenx_r)) + 40'(rs));
    end else begin
      loc_val = sat32(40'($signed(ceny_r)) + 40'(rs));
    end
  end

  always_comb begin
    case (tsel_r)
      TRIG_TILT_X: tangle = tiltx_r;
      TRIG_TILT_Y: tangle = tilty_r;
      TRIG_SPIN:   tangle = spin_r;
      default:     tangle = orbit_r;
    endcase
    // Fold into a quarter turn either side of zero; the results of a folded angle are negated at the end.
    tflip = tangle[31] ^ tangle[30];
    tfold = tflip ? (tangle + 32'h80000000) : tangle;
    xs = x_r >>> it_r;
    ys = y_r >>> it_r;
    if (!z_r[DW-1]) begin
      nx = x_r - ys;
      ny = y_r + xs;
      nz = z_r - atan_unit(5'(it_r));
    end else begin
      nx = x_r + ys;
      ny = y_r - xs;
      nz = z_r + atan_unit(5'(it_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      radius_r <= '0;
      speed_r  <= '0;
      scx_r    <= ONE;
      scy_r    <= ONE;
      scz_r    <= ONE;
      tiltx_r  <= '0;
      tilty_r  <= '0;
      height_r <= '0;
      locx_r   <= '0;
      locy_r   <= '0;
      spin_r   <= '0;
      orbit_r  <= '0;
      wb_vld_r <= 1'b0;
      col_r    <= '0;
      pc_r     <= '0;
      it_r     <= '0;
      tsel_r   <= TRIG_TILT_X;
      emit_r   <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_ORBIT_RADIUS: radius_r <= cfg_ch.data[30:0];
          REG_ORBIT_SPEED:  speed_r  <= cfg_ch.data;
          REG_SCALE_X:      scx_r    <= cfg_ch.data;
          REG_SCALE_Y:      scy_r    <= cfg_ch.data;
          REG_SCALE_Z:      scz_r    <= cfg_ch.data;
          REG_TILT_X:       tiltx_r  <= cfg_ch.data;
          REG_TILT_Y:       tilty_r  <= cfg_ch.data;
          REG_HEIGHT_Z:     height_r <= cfg_ch.data;
          default: ;
        endcase
      end

      wb_vld_r <= 1'b0;
      if (wb_vld_r) begin
        case (wb_step_r.dst)
          S_P1:   p1_r  <= wb_val;
          S_P2:   p2_r  <= wb_val;
          S_R00:  r00_r <= wb_val;
          S_R01:  r01_r <= wb_val;
          S_R02:  r02_r <= wb_val;
          S_R10:  r10_r <= wb_val;
          S_R11:  r11_r <= wb_val;
          S_R12:  r12_r <= wb_val;
          S_R20:  r20_r <= wb_val;
          S_R21:  r21_r <= wb_val;
          S_R22:  r22_r <= wb_val;
          S_LOCX: locx_r <= loc_val;
          S_LOCY: locy_r <= loc_val;
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            cenx_r <= in_ch.center_x;
            ceny_r <= in_ch.center_y;
            case (mode_t'(in_ch.mode))
              MODE_SPIN:    spin_r  <= spin_r - in_ch.spin_step;
              MODE_ADVANCE: orbit_r <= orbit_r + speed_r;
              MODE_ORBIT: begin
                emit_r  <= 1'b0;
                tsel_r  <= TRIG_ORBIT;
                state_r <= ST_TLOAD;
              end
              default: begin
                emit_r  <= 1'b1;
                tsel_r  <= TRIG_TILT_X;
                state_r <= ST_TLOAD;
              end
            endcase
          end
        end
        ST_TLOAD: begin
          x_r     <= CORDIC_GAIN;
          y_r     <= '0;
          z_r     <= sval_t'($signed(tfold));
          flip_r  <= tflip;
          it_r    <= '0;
          state_r <= ST_TRIG;
        end
        ST_TRIG: begin
          x_r  <= nx;
          y_r  <= ny;
          z_r  <= nz;
          it_r <= it_r + 1'b1;
          if (it_r == ITW'(TRIG_ITERATIONS - 1)) begin
            case (tsel_r)
              TRIG_TILT_X: begin
                cx_r <= flip_r ? -nx : nx;
                sx_r <= flip_r ? -ny : ny;
                tsel_r  <= TRIG_TILT_Y;
                state_r <= ST_TLOAD;
              end
              TRIG_TILT_Y: begin
                cy_r <= flip_r ? -nx : nx;
                sy_r <= flip_r ? -ny : ny;
                tsel_r  <= TRIG_SPIN;
                state_r <= ST_TLOAD;
              end
              default: begin
                cz_r <= flip_r ? -nx : nx;
                sz_r <= flip_r ? -ny : ny;
                pc_r    <= emit_r ? '0 : PC_ORBIT_BEGIN;
                state_r <= ST_MUL;
              end
            endcase
          end
        end
        ST_MUL: begin
          // One product issues per cycle; its result is written back in the next cycle.
          prod_r    <= PW'(op_a) * PW'(op_b);
          wb_step_r <= cur_step;
          wb_vld_r  <= 1'b1;
          pc_r      <= pc_r + 1'b1;
          if (pc_r == (emit_r ? PC_MATRIX_END : PC_ORBIT_END)) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          col_r   <= '0;
          state_r <= emit_r ? ST_OUT : ST_IDLE;
        end
        ST_OUT: begin
          if (out_ch.ready) begin
            col_r <= col_r + 1'b1;
            if (col_r == 2'd3) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.column = col_r;
  assign out_ch.last   = (col_r == 2'd3);

  always_comb begin
    case (col_r)
      2'd0: begin
        out_ch.elem_row0 = r00_r[31:0];
        out_ch.elem_row1 = r10_r[31:0];
        out_ch.elem_row2 = r20_r[31:0];
        out_ch.elem_row3 = '0;
      end
      2'd1: begin
        out_ch.elem_row0 = r01_r[31:0];
        out_ch.elem_row1 = r11_r[31:0];
        out_ch.elem_row2 = r21_r[31:0];
        out_ch.elem_row3 = '0;
      end
      2'd2: begin
        out_ch.elem_row0 = r02_r[31:0];
        out_ch.elem_row1 = r12_r[31:0];
        out_ch.elem_row2 = r22_r[31:0];
        out_ch.elem_row3 = '0;
      end
      default: begin
        out_ch.elem_row0 = locx_r;
        out_ch.elem_row1 = locy_r;
        out_ch.elem_row2 = height_r;
        out_ch.elem_row3 = ONE;
      end
    endcase
  end

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input ready while a column transaction is pending");

  a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last |=> in_ch.ready)
    else $error("block not ready after the final column");

  a_no_wb_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wb_vld_r |-> $past(state_r == ST_MUL))
    else $error("product written back without an issue");

endmodule

// ===== tb/orbit_and_model_matrix_core_test.sv =====
`timescale 1ns / 1ps
module orbit_and_model_matrix_core_test;
  import orbm_pkg::*;

  localparam int FRAC = 16;
  localparam int ITERS = 16;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  orbm_in_if  in_ch();
  orbm_out_if out_ch();
  orbm_cfg_if cfg_ch();

  orbit_and_model_matrix_core #(.FRAC_BITS(FRAC), .TRIG_ITERATIONS(ITERS)) u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  typedef struct {
    logic [1:0]  column;
    logic [31:0] row0;
    logic [31:0] row1;
    logic [31:0] row2;
    logic [31:0] row3;
    logic        last;
  } column_t;

  column_t expected_columns[$];

  // Predictor copy of the registers and the body state.
  logic [30:0] p_radius;
  logic [31:0] p_speed, p_scale_x, p_scale_y, p_scale_z, p_tilt_x, p_tilt_y, p_height;
  logic [31:0] p_loc_x, p_loc_y, p_spin, p_orbit;

  int  failures = 0;
  int  idle_cycles = 0;
  bit  hold_off = 0;
  bit  calm = 0;
  int  hold_cycles = 0;

  function automatic longint round_off30(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic longint atan_of(int i);
    longint t[24] = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98,
      64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE,
      64'h0000145F, 64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3,
      64'h00000051};
    return t[i];
  endfunction

  task automatic cordic_trig(input logic [31:0] angle, output longint c, output longint s);
    logic [31:0] a;
    bit flip;
    longint x, y, z, nx;
    a = angle;
    flip = 0;
    x = 652032874;
    y = 0;
    if (((a + 32'h40000000) & 32'h80000000) != 0) begin
      a = a + 32'h80000000;
      flip = 1;
    end
    z = longint'($signed(a));
    for (int i = 0; i < ITERS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_of(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_of(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint tprod(longint a, longint b);
    return round_off30(a * b);
  endfunction

  function automatic logic [31:0] scale_entry(longint r, logic [31:0] sc);
    return clamp32(round_off30(r * longint'($signed(sc))));
  endfunction

  task automatic reset_model();
    p_radius = '0; p_speed = '0;
    p_scale_x = 32'h1 << FRAC; p_scale_y = 32'h1 << FRAC; p_scale_z = 32'h1 << FRAC;
    p_tilt_x = '0; p_tilt_y = '0; p_height = '0;
    p_loc_x = '0; p_loc_y = '0; p_spin = '0; p_orbit = '0;
  endtask

  task automatic apply_body_update(input mode_t mode, input logic [31:0] cx_in,
                                   input logic [31:0] cy_in, input logic [31:0] step);
    longint c, s, cx, sx, cy, sy, cz, sz, r[3][3];
    logic [31:0] m[4][4];
    column_t col;
    case (mode)
      MODE_SPIN: p_spin = p_spin - step;
      MODE_ADVANCE: p_orbit = p_orbit + p_speed;
      MODE_ORBIT: begin
        cordic_trig(p_orbit, c, s);
        p_loc_x = clamp32(longint'($signed(cx_in)) + round_off30(longint'(p_radius) * c));
        p_loc_y = clamp32(longint'($signed(cy_in)) + round_off30(longint'(p_radius) * s));
      end
      default: begin
        cordic_trig(p_tilt_x, cx, sx);
        cordic_trig(p_tilt_y, cy, sy);
        cordic_trig(p_spin, cz, sz);
        r[0][0] = tprod(cy, cz);
        r[0][1] = -tprod(cy, sz);
        r[0][2] = sy;
        r[1][0] = tprod(cx, sz) + tprod(sx, tprod(sy, cz));
        r[1][1] = tprod(cx, cz) - tprod(sx, tprod(sy, sz));
        r[1][2] = -tprod(sx, cy);
        r[2][0] = tprod(sx, sz) - tprod(cx, tprod(sy, cz));
        r[2][1] = tprod(sx, cz) + tprod(cx, tprod(sy, sz));
        r[2][2] = tprod(cx, cy);
        for (int row = 0; row < 3; row++) begin
          m[0][row] = scale_entry(r[row][0], p_scale_x);
          m[1][row] = scale_entry(r[row][1], p_scale_y);
          m[2][row] = scale_entry(r[row][2], p_scale_z);
        end
        m[0][3] = '0; m[1][3] = '0; m[2][3] = '0;
        m[3][0] = p_loc_x; m[3][1] = p_loc_y; m[3][2] = p_height; m[3][3] = 32'h1 << FRAC;
        for (int k = 0; k < 4; k++) begin
          col.column = k[1:0];
          col.row0 = m[k][0]; col.row1 = m[k][1]; col.row2 = m[k][2]; col.row3 = m[k][3];
          col.last = (k == 3);
          expected_columns.insert(expected_columns.size(), col);
        end
      end
    endcase
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_ORBIT_RADIUS: p_radius = value[30:0];
      REG_ORBIT_SPEED:  p_speed = value;
      REG_SCALE_X:      p_scale_x = value;
      REG_SCALE_Y:      p_scale_y = value;
      REG_SCALE_Z:      p_scale_z = value;
      REG_TILT_X:       p_tilt_x = value;
      REG_TILT_Y:       p_tilt_y = value;
      default:          p_height = value;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Sends one transaction; valid stays high between items if calm is set.
  task automatic send_item(input mode_t mode, input logic [31:0] cx_in,
                           input logic [31:0] cy_in, input logic [31:0] step);
    if (!calm) begin
      while ($urandom_range(99) < 13) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.center_x <= cx_in;
    in_ch.center_y <= cy_in;
    in_ch.spin_step <= step;
    do @(posedge clk); while (!in_ch.ready);
    apply_body_update(mode, cx_in, cy_in, step);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_columns.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic test_directed();
    logic [31:0] ext[4] = '{32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000};
    send_item(MODE_EMIT, '0, '0, '0);
    foreach (ext[i]) send_item(MODE_SPIN, ext[i], ext[3 - i], ext[i]);
    send_item(MODE_EMIT, '0, '0, '0);
    send_item(MODE_ADVANCE, '0, '0, '0);
    send_item(MODE_ORBIT, 32'h7FFFFFFF, 32'h80000000, '0);
    send_item(MODE_EMIT, '0, '0, '0);
    drain();
    write_register(REG_ORBIT_RADIUS, 32'hFFFFFFFF);
    write_register(REG_ORBIT_SPEED, 32'h40000000);
    write_register(REG_SCALE_X, 32'h7FFFFFFF);
    write_register(REG_SCALE_Y, 32'h80000000);
    write_register(REG_SCALE_Z, 32'h00000000);
    write_register(REG_TILT_X, 32'h20000000);
    write_register(REG_TILT_Y, 32'hC0000000);
    write_register(REG_HEIGHT_Z, 32'h80000000);
    // Saturating orbit step in both directions, then the quarter turns.
    send_item(MODE_ORBIT, 32'h7FFFFFFF, 32'h7FFFFFFF, '0);
    send_item(MODE_EMIT, '0, '0, '0);
    send_item(MODE_ADVANCE, '0, '0, '0);
    send_item(MODE_ADVANCE, '0, '0, '0);
    send_item(MODE_ORBIT, 32'h80000000, 32'h80000000, '0);
    send_item(MODE_SPIN, '0, '0, 32'h40000000);
    send_item(MODE_EMIT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    drain();
  endtask

  task automatic test_random_phase(input int count);
    logic [31:0] cxv, cyv;
    for (int i = 0; i < count; i++) begin
      cxv = $urandom();
      cyv = $urandom();
      if ($urandom_range(3) == 0) cxv = {{14{cxv[31]}}, cxv[17:0]};
      send_item(mode_t'($urandom_range(3)), cxv, cyv, $urandom());
    end
  endtask

  task automatic test_register_settings();
    reg_idx_t idx;
    for (int phase = 0; phase < 6; phase++) begin
      for (int k = 0; k < 8; k++) begin
        idx = reg_idx_t'(k);
        if (k >= int'(REG_SCALE_X) && k <= int'(REG_SCALE_Z) && $urandom_range(1))
          write_register(idx, $urandom_range(32'h30000) - 32'h18000);
        else
          write_register(idx, $urandom());
      end
      calm = (phase == 2);
      test_random_phase(65);
      calm = 0;
      drain();
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    hold_off = 1;
    for (int i = 0; i < 8; i++) send_item(MODE_EMIT, $urandom(), $urandom(), $urandom());
    drain();
  endtask

  // Result checker.
  always @(posedge clk) begin
    column_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_columns.size() == 0) begin
        $error("unexpected column transaction %0d", out_ch.column);
        failures++;
      end else begin
        want = expected_columns.pop_front();
        if (out_ch.column !== want.column) begin
          $error("column: expected %0d actual %0d", want.column, out_ch.column); failures++;
        end
        if (out_ch.elem_row0 !== want.row0) begin
          $error("elem_row0: expected %h actual %h", want.row0, out_ch.elem_row0); failures++;
        end
        if (out_ch.elem_row1 !== want.row1) begin
          $error("elem_row1: expected %h actual %h", want.row1, out_ch.elem_row1); failures++;
        end
        if (out_ch.elem_row2 !== want.row2) begin
          $error("elem_row2: expected %h actual %h", want.row2, out_ch.elem_row2); failures++;
        end
        if (out_ch.elem_row3 !== want.row3) begin
          $error("elem_row3: expected %h actual %h", want.row3, out_ch.elem_row3); failures++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d actual %0d", want.last, out_ch.last); failures++;
        end
      end
    end
  end

  // Receiver: random stalls unless calm, or a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_off) begin
      out_ch.ready <= 1'b0;
      if (hold_cycles == 0) hold_off <= 0;
      else hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 13);
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n || hold_off)
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** orbit_and_model_matrix_core: FAILED **");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.mode = '0;
    in_ch.center_x = '0; in_ch.center_y = '0; in_ch.spin_step = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    reset_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_register_settings();
    if (failures == 0 && expected_columns.size() == 0)
      $display("** orbit_and_model_matrix_core: PASSED **");
    else
      $display("** orbit_and_model_matrix_core: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/orbm_pkg.sv
hw/rtl/orbm_if.sv
hw/rtl/orbit_and_model_matrix_core.sv
tb/orbit_and_model_matrix_core_test.sv
